### rtl/slc_pkg.sv
package slc_pkg;

  // tally width, outputs always carry the low OUT_BITS bits
  localparam int COUNT_BITS = 32;
  localparam int OUT_BITS   = 32;
  localparam int CHAR_BITS  = 8;
  localparam int DATA_BITS  = 4 * OUT_BITS;

  localparam logic [CHAR_BITS-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_BITS-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_BITS-1:0] CH_STAR  = 8'h2A;

  typedef logic [COUNT_BITS-1:0] tally_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] line_count;
    logic [OUT_BITS-1:0] code_count;
    logic [OUT_BITS-1:0] comment_count;
    logic [OUT_BITS-1:0] blank_count;
  } counts_t;

  // per-line scan flags, cleared when a line closes
  typedef struct packed {
    logic [CHAR_BITS-1:0] prev_byte;
    logic                 line_nonempty;
    logic                 saw_opener;
    logic                 saw_slash_pair;
    logic                 saw_closer;
    logic                 marker_seen;
    logic                 text_before_marker;
  } line_state_t;

  function automatic tally_t sat_inc(input tally_t t, input logic en);
    if (en && (t != '1)) begin
      sat_inc = t + tally_t'(1);
    end else begin
      sat_inc = t;
    end
  endfunction

endpackage

### rtl/source_line_classifier.sv
// Counts the lines of a source file streamed in one byte per request: each line, closed by a
// newline or by the byte flagged with tlast, is tallied as blank, comment, code and total, with
// slash-star block comments carried across lines until a line holding star-slash or end of file.
// One byte is taken every cycle; the line flags and tallies are registered as each byte is
// taken, and its result sits in an output register from the next cycle, so the input keeps
// flowing while that register is empty or drained. Every byte yields one result; tuser
// marks the results where a line closed.
module source_line_classifier (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [slc_pkg::CHAR_BITS-1:0] s_tdata,   // char_in
  input  logic                          s_tlast,   // file_end
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [slc_pkg::DATA_BITS-1:0] m_tdata,   // blank, comment, code, line counts
  output logic [0:0]                    m_tuser    // line_done
);
  import slc_pkg::*;

  line_state_t line_st, line_st_next;
  logic        in_block, in_block_next;
  tally_t      blank_total, comment_total, code_total, all_total;
  tally_t      blank_next, comment_next, code_next, all_next;
  logic        accept;

  logic        is_nl, close;
  logic        opener_hit, slash_hit, closer_hit;
  line_state_t scan;
  logic        bump_blank, bump_comment, bump_code;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign is_nl    = (s_tdata == CH_NL);
  assign close    = is_nl || s_tlast;

  always_comb begin
    opener_hit = (line_st.prev_byte == CH_SLASH) && (s_tdata == CH_STAR);
    slash_hit  = (line_st.prev_byte == CH_SLASH) && (s_tdata == CH_SLASH);
    closer_hit = (line_st.prev_byte == CH_STAR) && (s_tdata == CH_SLASH);

    scan = line_st;
    if (!is_nl) begin
      scan.line_nonempty = 1'b1;
      scan.prev_byte     = s_tdata;
      if (opener_hit) scan.saw_opener     = 1'b1;
      if (slash_hit)  scan.saw_slash_pair = 1'b1;
      if (closer_hit) scan.saw_closer     = 1'b1;
      if (!line_st.marker_seen) begin
        if (line_st.prev_byte == CH_SLASH) begin
          if (opener_hit || slash_hit) scan.marker_seen = 1'b1;
          else                         scan.text_before_marker = 1'b1;
        end
        // a lone slash waits for the next byte to decide it
        if (!scan.marker_seen && (s_tdata != CH_SPACE) && (s_tdata != CH_SLASH)) begin
          scan.text_before_marker = 1'b1;
        end
      end
    end

    bump_blank    = 1'b0;
    bump_comment  = 1'b0;
    bump_code     = 1'b0;
    in_block_next = in_block;
    if (close) begin
      if (in_block) begin
        bump_comment = 1'b1;
        if (scan.saw_closer) in_block_next = 1'b0;
      end else if (!scan.line_nonempty) begin
        bump_blank = 1'b1;
      end else if (scan.saw_opener || scan.saw_slash_pair) begin
        bump_comment = 1'b1;
        bump_code    = scan.text_before_marker;
        if (scan.saw_opener && !scan.saw_closer) in_block_next = 1'b1;
      end else begin
        bump_code = 1'b1;
      end
    end
    // block mode never carries into the next file
    if (s_tlast) in_block_next = 1'b0;

    line_st_next = close ? '0 : scan;
    blank_next   = sat_inc(blank_total, bump_blank);
    comment_next = sat_inc(comment_total, bump_comment);
    code_next    = sat_inc(code_total, bump_code);
    all_next     = sat_inc(all_total, close);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_st       <= '0;
      in_block      <= 1'b0;
      blank_total   <= '0;
      comment_total <= '0;
      code_total    <= '0;
      all_total     <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (accept) begin
        line_st       <= line_st_next;
        in_block      <= in_block_next;
        blank_total   <= blank_next;
        comment_total <= comment_next;
        code_total    <= code_next;
        all_total     <= all_next;
        m_tvalid      <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  counts_t counts_next;

  always_comb begin
    counts_next.blank_count   = OUT_BITS'(blank_next);
    counts_next.comment_count = OUT_BITS'(comment_next);
    counts_next.code_count    = OUT_BITS'(code_next);
    counts_next.line_count    = OUT_BITS'(all_next);
  end

  // payload register, loaded with every accepted byte
  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata    <= counts_next;
      m_tuser[0] <= close;
    end
  end

endmodule

### rtl/slc_checker.sv
module slc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [slc_pkg::CHAR_BITS-1:0] s_tdata,
  input logic                          s_tlast,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [slc_pkg::DATA_BITS-1:0] m_tdata,
  input logic [0:0]                    m_tuser
);
  import slc_pkg::*;

  counts_t counts;
  assign counts = m_tdata;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // a newline request closes a line in the very next result
  a_nl_closes: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tdata == CH_NL) |=> m_tvalid && m_tuser[0])
    else $error("newline did not close a line");

  // an ordinary byte mid-file never closes a line
  a_plain_open: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tdata != CH_NL) && !s_tlast |=> m_tvalid && !m_tuser[0])
    else $error("line closed without newline or file end");

  // blank and comment lines are each part of the total
  a_totals: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (counts.blank_count <= counts.line_count) &&
                 (counts.comment_count <= counts.line_count))
    else $error("partial tally exceeds line total");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind source_line_classifier slc_checker u_slc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
